[rtl/tts_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the tick task scheduler table
// no dependencies
package tts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TICK_W        = 10;
    localparam int MS_W          = 32;
    localparam int HANDLE_W      = 8;
    localparam int PEND_W        = 8;
    localparam logic [TICK_W-1:0] TICK_RESET = 10'd10;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_TICK     = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_DELETE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RK_ADD    = 2'd0,
        RK_DELETE = 2'd1,
        RK_RUN    = 2'd2,
        RK_DONE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [MS_W-1:0]     countdown;
        logic [MS_W-1:0]     period;
        logic [PEND_W-1:0]   pending;
    } entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic   load;      // write new entry at tail
        logic   tick;
        logic   shift;     // flagged cells take neighbor
        logic   dec_pend;  // with rotate: entry moving into cell sel loses one pending run
        logic   rotate;    // rotate row by one toward slot 0
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK,
        ST_OUT,
        ST_SHIFT
    } state_t;

endpackage

[rtl/tts_div.sv]
`timescale 1ns / 1ps
// restoring bit-serial divider, one quotient bit per cycle
// depends on tts_pkg
module tts_div
    import tts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MS_W-1:0]   dividend,
    input  logic [TICK_W-1:0] divisor,
    output logic              busy,
    output logic [MS_W-1:0]   quotient
);

    logic [MS_W-1:0]   q_reg, q_next;
    logic [TICK_W-1:0] r_reg, r_next;
    logic [TICK_W-1:0] d_reg, d_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [TICK_W:0]   trial;

    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        trial    = {r_reg, q_reg[MS_W-1]};
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = (divisor == '0) ? TICK_W'(1) : divisor;
            cnt_next = 6'(MS_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = TICK_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[MS_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[TICK_W-1:0];
                q_next = {q_reg[MS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;

endmodule

[rtl/tts_cell.sv]
`timescale 1ns / 1ps
// one table slot; takes its upper neighbor's entry on shift or rotate
// depends on tts_pkg
module tts_cell
    import tts_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  logic      is_tail,
    input  logic      at_sel,
    input  logic      shift_en,
    input  logic      active,
    input  entry_t    new_entry,
    input  entry_t    upper,
    output entry_t    entry
);

    entry_t e_reg, e_next;

    always_comb
    begin
        e_next = e_reg;
        if (cmd.load && is_tail)
            e_next = new_entry;
        else if (cmd.rotate)
        begin
            e_next = upper;
            if (cmd.dec_pend && at_sel)
                e_next.pending = upper.pending - PEND_W'(1);
        end
        else if (cmd.shift && shift_en)
            e_next = upper;
        else if (cmd.tick && active)
        begin
            if (e_reg.countdown != '0)
                e_next.countdown = e_reg.countdown - MS_W'(1);
            else
            begin
                e_next.countdown = e_reg.period;
                if (e_reg.pending != '1)
                    e_next.pending = e_reg.pending + PEND_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
    end

    assign entry = e_reg;

endmodule

[rtl/tick_task_scheduler_table_core.sv]
`timescale 1ns / 1ps
// top level of the tick task scheduler table: control, divider and row of slot cells
// depends on tts_pkg, tts_div, tts_cell
// One transaction at a time; a new command is taken only in idle, which follows
// the state that loads the last result of the previous one. Tick updates all active
// cells at once; delete moves every later slot down at once when the slot exists;
// add runs the bit-serial divider for the delay and then the period, unless the
// table is full; dispatch rotates the row past slot 0 one slot per cycle while the
// output register can take a result, and drops each one-shot task that runs. Results
// leave through an output register, so a stalled receiver holds the walk and the result.
module tick_task_scheduler_table_core
    import tts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // task_handle, delay_ms, period_ms, task_slot
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // result_kind, success, run_handle
    output logic        m_tlast,   // last_result
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data   // tick_length_ms
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    state_t state_reg, state_next;
    logic [TICK_W-1:0] tick_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] pos_reg, pos_next;     // dispatch: slots kept so far
    logic [CW-1:0] rot_reg, rot_next;     // rotations done in dispatch
    logic [1:0] op_reg;
    logic [HANDLE_W-1:0] h_reg;
    logic [MS_W-1:0] delay_reg, period_reg, qd_reg;
    logic [3:0] slot_reg;
    logic phase_reg, phase_next;
    logic ovalid_reg;
    logic [1:0] okind_reg;
    logic oks_reg, olast_reg;
    logic [HANDLE_W-1:0] oh_reg;
    logic emit;
    logic [1:0] ekind;
    logic eok, elast;
    logic [HANDLE_W-1:0] eh;
    cell_cmd_t cmd;
    logic [IW-1:0] sel;
    logic div_start, div_busy;
    logic [MS_W-1:0] div_q;
    entry_t ent [MAX_TASKS];
    entry_t new_entry;
    logic [CW-1:0] full_w;

    assign full_w    = CW'(MAX_TASKS);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = {5'd0, oh_reg, oks_reg, okind_reg};
    assign m_tlast   = olast_reg;

    tts_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(phase_reg ? period_reg : delay_reg),
        .divisor (tick_reg),
        .busy    (div_busy),
        .quotient(div_q)
    );

    assign new_entry = '{handle: h_reg, countdown: qd_reg, period: div_q, pending: '0};

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++)
        begin : g_cell
            entry_t up;
            if (g == MAX_TASKS - 1)
                assign up = ent[0];
            else
                assign up = ent[g+1];
            // delete moves the slots at and above sel; dispatch moves the
            // not yet rotated part of the row below the slots already kept
            tts_cell u_cell (
                .clk      (clk),
                .cmd      (cmd),
                .is_tail  (cnt_reg == CW'(g)),
                .at_sel   (sel == IW'(g)),
                .shift_en ((op_reg == OP_DELETE) ? (IW'(g) >= sel) :
                           (8'(g) + 8'(rot_reg) < 8'(MAX_TASKS))),
                .active   (CW'(g) < cnt_reg),
                .new_entry(new_entry),
                .upper    (up),
                .entry    (ent[g])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        rot_next   = rot_reg;
        phase_next = phase_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    pos_next   = '0;
                    rot_next   = '0;
                    phase_next = 1'b0;
                    case (s_tuser)
                        OP_ADD:
                            if (cnt_reg == full_w)
                                state_next = ST_OUT;
                            else
                                state_next = ST_DIV;
                        OP_DISPATCH: state_next = ST_WALK;
                        OP_DELETE:
                            if (8'(s_tdata[75:72]) < 8'(cnt_reg))
                            begin
                                state_next = ST_SHIFT;
                                pos_next   = CW'(s_tdata[75:72]);
                                phase_next = 1'b1;
                            end
                            else
                                state_next = ST_OUT;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    if (pos_reg == '0)
                    begin
                        div_start = 1'b1;
                        pos_next  = CW'(1);
                    end
                    else if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        pos_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                        cnt_next   = cnt_reg + CW'(1);
                    end
                end
            end
            ST_WALK:
            begin
                // slot under test sits at cell 0
                if (!ovalid_reg || m_tready)
                begin
                    if (pos_reg == cnt_reg)
                    begin
                        if (rot_reg == full_w)
                            state_next = ST_OUT;
                        else
                            rot_next = rot_reg + CW'(1);
                    end
                    else if (ent[0].pending != '0)
                    begin
                        if (ent[0].period == '0)
                            cnt_next = cnt_reg - CW'(1);
                        else
                        begin
                            pos_next = pos_reg + CW'(1);
                            rot_next = rot_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + CW'(1);
                        rot_next = rot_reg + CW'(1);
                    end
                end
            end
            ST_SHIFT:
            begin
                state_next = ST_OUT;
                cnt_next   = cnt_reg - CW'(1);
            end
            ST_OUT:
                if (!ovalid_reg || m_tready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and cell commands
    always_comb
    begin
        cmd   = '0;
        sel   = '0;
        emit  = 1'b0;
        ekind = RK_DONE;
        eok   = 1'b0;
        eh    = '0;
        elast = 1'b1;
        case (state_reg)
            ST_IDLE:
                cmd.tick = s_tvalid && (s_tuser == OP_TICK);
            ST_DIV:
                cmd.load = !div_busy && pos_reg != '0 && phase_reg;
            ST_WALK:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    if (pos_reg == cnt_reg)
                        cmd.rotate = (rot_reg != full_w);
                    else if (ent[0].pending != '0)
                    begin
                        emit  = 1'b1;
                        ekind = RK_RUN;
                        eh    = ent[0].handle;
                        elast = 1'b0;
                        if (ent[0].period == '0)
                            cmd.shift = 1'b1; // drop cell 0, later slots move down
                        else
                        begin
                            cmd.rotate   = 1'b1;
                            cmd.dec_pend = 1'b1;
                            sel          = IW'(MAX_TASKS - 1);
                        end
                    end
                    else
                        cmd.rotate = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                sel       = IW'(slot_reg);
            end
            ST_OUT:
            begin
                emit = !ovalid_reg || m_tready;
                case (op_reg)
                    OP_ADD:
                    begin
                        ekind = RK_ADD;
                        eok   = (cnt_reg != full_w) || phase_reg;
                        eh    = eok ? HANDLE_W'(cnt_reg - CW'(1)) : '0;
                    end
                    OP_DELETE:
                    begin
                        ekind = RK_DELETE;
                        eok   = pos_reg != '0 || phase_reg;
                    end
                    default: ekind = RK_DONE;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            tick_reg   <= TICK_RESET;
            ovalid_reg <= 1'b0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            if (cfg_valid)
                tick_reg <= cfg_data;
            if (emit)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        rot_reg <= rot_next;
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            op_reg     <= s_tuser;
            h_reg      <= s_tdata[7:0];
            delay_reg  <= s_tdata[39:8];
            period_reg <= s_tdata[71:40];
            slot_reg   <= s_tdata[75:72];
        end
        if (state_reg == ST_DIV && !div_busy && pos_reg != '0 && !phase_reg)
            qd_reg <= div_q;
        if (emit)
        begin
            okind_reg <= ekind;
            oks_reg   <= eok;
            oh_reg    <= eh;
            olast_reg <= elast;
        end
    end

endmodule
